/* rtl/core/dhsr_pkg.sv */
`timescale 1ns / 1ps

// Shared widths, codes and types for the double hashing slot reserver.
package dhsr_pkg;

	// Fixed field widths of the command and result items.
	localparam int FIELD_W   = 12;
	localparam int OP_W      = 2;
	localparam int STATUS_W  = 2;
	localparam int CNT_W     = 13;
	localparam int CFG_W     = 13;
	localparam int LIMIT_W   = 12;
	localparam int CFG_IDX_W = 1;

	// Width of the clear epoch kept per slot, and of the reduction step counter.
	localparam int EPOCH_W   = 4;
	localparam int RED_CNT_W = $clog2(FIELD_W);

	typedef logic [OP_W-1:0]      op_t;
	typedef logic [STATUS_W-1:0]  status_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Operation codes.
	localparam op_t OP_CLEAR   = 2'd0;
	localparam op_t OP_MARK    = 2'd1;
	localparam op_t OP_RESERVE = 2'd2;

	// Result status codes.
	localparam status_t STATUS_OK        = 2'd0;
	localparam status_t STATUS_ABANDONED = 2'd1;
	localparam status_t STATUS_FULL      = 2'd2;

	// Configuration register indexes.
	localparam cfg_idx_t REG_TABLE_SIZE  = 1'd0;
	localparam cfg_idx_t REG_PROBE_LIMIT = 1'd1;

	// Reset value of the table size register.
	localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 13'd4096;

endpackage

/* rtl/core/double_hash_slot_reserver_core.sv */
`timescale 1ns / 1ps

// Channel   | Signals                                            | Handshake
// ----------+----------------------------------------------------+---------------------------
// command   | op, start_slot, probe_stride                       | taken when start && !busy
// result    | slot, status, probes, max_probes_seen,             | valid while done is high,
//           | reserved_count                                     | for one cycle only
// config    | cfg_index, cfg_wdata                               | written when cfg_we is high
//
// Clear, mark and unused ops give their result from the dispatch state, without a probe.
// A reserve then probes slots in turn: the occupancy memory is read once per cycle.
// A start slot or stride not below the table size first goes through bit-serial reduction.
// After reset, and after every fifteenth clear, a sweep over all TABLE_MAX slots wipes the occupancy
// memory; busy stays high meanwhile. The receiver cannot stall results.
module double_hash_slot_reserver_core import dhsr_pkg::*; #(
	parameter int TABLE_MAX = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  cfg_idx_t           cfg_index,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic               start,
	input  op_t                op,
	input  logic [FIELD_W-1:0] start_slot,
	input  logic [FIELD_W-1:0] probe_stride,
	output logic               busy,
	output logic               done,
	output logic [FIELD_W-1:0] slot,
	output status_t            status,
	output logic [CNT_W-1:0]   probes,
	output logic [CNT_W-1:0]   max_probes_seen,
	output logic [CNT_W-1:0]   reserved_count
);

	localparam int AW = $clog2(TABLE_MAX);
	localparam int SW = $clog2(TABLE_MAX + 1);
	localparam int CW = (SW > CFG_W) ? SW : CFG_W;
	localparam int NW = AW + 1;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_REDUCE,
		ST_DISPATCH,
		ST_PROBE
	} state_t;

	state_t               state_q;
	logic [CFG_W-1:0]     table_size_q;
	logic [LIMIT_W-1:0]   probe_limit_q;
	logic [EPOCH_W-1:0]   epoch_q;
	logic [AW-1:0]        sweep_q;
	op_t                  op_q;
	logic [AW-1:0]        first_q;
	logic [AW-1:0]        stride_q;
	logic [AW-1:0]        idx_q;
	logic [CNT_W-1:0]     depth_q;
	logic [CNT_W-1:0]     longest_q;
	logic [CNT_W-1:0]     total_q;
	logic                 abandoned_q;
	logic                 done_q;
	logic [FIELD_W-1:0]   slot_q;
	status_t              status_q;
	logic [CNT_W-1:0]     probes_q;
	logic [CNT_W-1:0]     max_probes_q;
	logic [CNT_W-1:0]     reserved_q;

	// Occupancy memory: each slot holds the epoch of the clear it was last taken in.
	logic [EPOCH_W-1:0]   epoch_mem [TABLE_MAX];
	logic [EPOCH_W-1:0]   rd_q;
	logic                 mem_we;
	logic [AW-1:0]        mem_wa;
	logic [EPOCH_W-1:0]   mem_wd;
	logic [AW-1:0]        mem_ra;

	logic [CW-1:0]        ts_ext;
	logic [SW-1:0]        size_w;
	logic                 fast;
	logic [NW-1:0]        sum_w;
	logic [AW-1:0]        nxt_w;
	logic                 occ;
	logic                 limit_hit;
	logic [CNT_W-1:0]     new_longest;
	logic                 red_go;
	logic                 red_done;
	logic [SW-1:0]        red_rem_a;
	logic [SW-1:0]        red_rem_b;

	// Effective table size, clamped to the supported range.
	always_comb begin
		ts_ext = CW'(table_size_q);
		if (ts_ext < CW'(2)) begin
			size_w = SW'(2);
		end else if (ts_ext > CW'(TABLE_MAX)) begin
			size_w = SW'(TABLE_MAX);
		end else begin
			size_w = SW'(ts_ext);
		end
	end

	// Slot and stride already below the size need no reduction.
	assign fast = (CW'(start_slot) < CW'(size_w)) && (CW'(probe_stride) < CW'(size_w));
	assign red_go = (state_q == ST_IDLE) && start && !fast;

	dhsr_reduce #(
		.SZ_W (SW)
	) u_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (red_go),
		.a_in    (start_slot),
		.b_in    (probe_stride),
		.divisor (size_w),
		.done    (red_done),
		.rem_a   (red_rem_a),
		.rem_b   (red_rem_b)
	);

	// Next probe slot, wrapped once around the table size.
	always_comb begin
		sum_w = {1'b0, idx_q} + {1'b0, stride_q};
		if (sum_w >= NW'(size_w)) begin
			sum_w = sum_w - NW'(size_w);
		end
		nxt_w = sum_w[AW-1:0];
	end

	// A slot is occupied only if it carries the current epoch.
	assign occ         = (rd_q == epoch_q);
	assign limit_hit   = (probe_limit_q != '0) && (depth_q >= CNT_W'(probe_limit_q));
	assign new_longest = (depth_q > longest_q) ? depth_q : longest_q;

	// Memory port selection.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = first_q;
		mem_wd = epoch_q;
		mem_ra = nxt_w;
		case (state_q)
			ST_SWEEP: begin
				mem_we = 1'b1;
				mem_wa = sweep_q;
				mem_wd = '0;
			end
			ST_DISPATCH: begin
				mem_ra = first_q;
				mem_we = (op_q == OP_MARK);
			end
			ST_PROBE: begin
				mem_we = !occ;
				mem_wa = idx_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			epoch_mem[mem_wa] <= mem_wd;
		end
		rd_q <= epoch_mem[mem_ra];
	end

	// Sequencer, counters and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_SWEEP;
			table_size_q  <= TABLE_SIZE_RST;
			probe_limit_q <= '0;
			epoch_q       <= EPOCH_W'(1);
			sweep_q       <= '0;
			op_q          <= OP_CLEAR;
			first_q       <= '0;
			stride_q      <= '0;
			idx_q         <= '0;
			depth_q       <= '0;
			longest_q     <= '0;
			total_q       <= '0;
			abandoned_q   <= 1'b0;
			done_q        <= 1'b0;
			slot_q        <= '0;
			status_q      <= STATUS_OK;
			probes_q      <= '0;
			max_probes_q  <= '0;
			reserved_q    <= '0;
		end else begin
			done_q <= 1'b0;

			if (cfg_we) begin
				case (cfg_index)
					REG_TABLE_SIZE:  table_size_q  <= cfg_wdata;
					REG_PROBE_LIMIT: probe_limit_q <= cfg_wdata[LIMIT_W-1:0];
					default: begin
					end
				endcase
			end

			case (state_q)
				ST_SWEEP: begin
					if (sweep_q == AW'(TABLE_MAX - 1)) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end

				ST_IDLE: begin
					if (start) begin
						op_q <= op;
						if (fast) begin
							first_q  <= AW'(start_slot);
							stride_q <= AW'(probe_stride);
							state_q  <= ST_DISPATCH;
						end else begin
							state_q  <= ST_REDUCE;
						end
					end
				end

				ST_REDUCE: begin
					if (red_done) begin
						first_q  <= AW'(red_rem_a);
						stride_q <= AW'(red_rem_b);
						state_q  <= ST_DISPATCH;
					end
				end

				ST_DISPATCH: begin
					done_q       <= 1'b1;
					slot_q       <= '0;
					status_q     <= STATUS_OK;
					probes_q     <= '0;
					max_probes_q <= longest_q;
					reserved_q   <= total_q;
					state_q      <= ST_IDLE;
					case (op_q)
						OP_CLEAR: begin
							longest_q    <= '0;
							total_q      <= '0;
							abandoned_q  <= 1'b0;
							max_probes_q <= '0;
							reserved_q   <= '0;
							// Epochs are spent: wipe the memory and start again.
							if (epoch_q == '1) begin
								epoch_q <= EPOCH_W'(1);
								state_q <= ST_SWEEP;
							end else begin
								epoch_q <= epoch_q + 1'b1;
							end
						end
						OP_MARK: begin
							slot_q <= FIELD_W'(first_q);
						end
						OP_RESERVE: begin
							if (abandoned_q) begin
								status_q <= STATUS_ABANDONED;
							end else begin
								done_q  <= 1'b0;
								idx_q   <= first_q;
								depth_q <= CNT_W'(1);
								state_q <= ST_PROBE;
							end
						end
						default: begin
						end
					endcase
				end

				ST_PROBE: begin
					if (!occ) begin
						// Free slot found: it is taken by the memory write this cycle.
						longest_q    <= new_longest;
						total_q      <= total_q + 1'b1;
						done_q       <= 1'b1;
						slot_q       <= FIELD_W'(idx_q);
						status_q     <= STATUS_OK;
						probes_q     <= depth_q;
						max_probes_q <= new_longest;
						reserved_q   <= total_q + 1'b1;
						state_q      <= ST_IDLE;
					end else if (limit_hit) begin
						abandoned_q  <= 1'b1;
						done_q       <= 1'b1;
						slot_q       <= '0;
						status_q     <= STATUS_ABANDONED;
						probes_q     <= depth_q;
						max_probes_q <= longest_q;
						reserved_q   <= total_q;
						state_q      <= ST_IDLE;
					end else if (nxt_w == first_q) begin
						done_q       <= 1'b1;
						slot_q       <= '0;
						status_q     <= STATUS_FULL;
						probes_q     <= depth_q;
						max_probes_q <= longest_q;
						reserved_q   <= total_q;
						state_q      <= ST_IDLE;
					end else begin
						// The read of the next slot is already under way.
						idx_q   <= nxt_w;
						depth_q <= depth_q + 1'b1;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign done            = done_q;
	assign slot            = slot_q;
	assign status          = status_q;
	assign probes          = probes_q;
	assign max_probes_seen = max_probes_q;
	assign reserved_count  = reserved_q;

	// A failed item never reports a slot.
	a_fail_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != STATUS_OK) |-> slot == '0)
		else $error("failed item reports a nonzero slot");

	// Probe depth never exceeds the effective table size.
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> CW'(depth_q) <= CW'(size_w))
		else $error("probe depth beyond table size");

	// A result only follows a cycle in which an item was at work.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an item in progress");

	// The live epoch is never the wiped value.
	a_epoch_live: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_q != '0)
		else $error("current epoch equals the cleared tag");

endmodule

/* rtl/core/dhsr_reduce.sv */
`timescale 1ns / 1ps

// Reduces two field values modulo the table size, one quotient bit per cycle.
module dhsr_reduce import dhsr_pkg::*; #(
	parameter int SZ_W = 13
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [FIELD_W-1:0] a_in,
	input  logic [FIELD_W-1:0] b_in,
	input  logic [SZ_W-1:0]    divisor,
	output logic               done,
	output logic [SZ_W-1:0]    rem_a,
	output logic [SZ_W-1:0]    rem_b
);

	logic                 run_q;
	logic                 done_q;
	logic [RED_CNT_W-1:0] cnt_q;
	logic [FIELD_W-1:0]   a_q;
	logic [FIELD_W-1:0]   b_q;
	logic [SZ_W-1:0]      ra_q;
	logic [SZ_W-1:0]      rb_q;

	// One restoring step: bring in the next dividend bit and subtract if it fits.
	function automatic logic [SZ_W-1:0] rem_step(input logic [SZ_W-1:0] rem,
			input logic nbit, input logic [SZ_W-1:0] d);
		logic [SZ_W:0] t;
		t = {rem, nbit};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
		end
		return t[SZ_W-1:0];
	endfunction

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= RED_CNT_W'(FIELD_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Dividend shifters and partial remainders.
	always_ff @(posedge clk) begin
		if (go) begin
			a_q  <= a_in;
			b_q  <= b_in;
			ra_q <= '0;
			rb_q <= '0;
		end else if (run_q) begin
			ra_q <= rem_step(ra_q, a_q[FIELD_W-1], divisor);
			rb_q <= rem_step(rb_q, b_q[FIELD_W-1], divisor);
			a_q  <= {a_q[FIELD_W-2:0], 1'b0};
			b_q  <= {b_q[FIELD_W-2:0], 1'b0};
		end
	end

	assign done  = done_q;
	assign rem_a = ra_q;
	assign rem_b = rb_q;

endmodule
